[design/look_at_view_matrix_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the look-at view matrix block.
// Checks compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_TOP_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_MACROS_SVH
`ifndef SYNTH
`define LVM_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LVM_ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);
`else
`define LVM_ASSERT_HOLDS(lbl, ante, cons, msg)
`define LVM_ASSERT_AFTER_RESET(lbl, cons, msg)
`endif
`endif

[design/lvm_pkg.sv]
// ----------------------------------------------------------------------------
// lvm_pkg
// Widths, types and rounding helpers shared by the look-at view matrix block.
// ----------------------------------------------------------------------------
package lvm_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 18;
  localparam int SHIFT_W    = 32;
  localparam int UNIT_W     = FRAC_BITS + 2;
  localparam int VEC_W      = 64;
  localparam int NORM_W     = 31;
  localparam int SQ_W       = 2 * NORM_W;
  localparam int SUM_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int QB         = FRAC_BITS + 2;
  localparam int DREM_W     = ROOT_W + QB;
  localparam int POS_W      = 6;
  localparam int CHUNKS     = 4;
  localparam int P_W        = UNIT_W + IN_W;
  localparam int CROSS_W    = P_W + 1;
  localparam int PROD_W     = P_W + 4;
  localparam int UNIT_LAT   = 7 + SQRT_STEPS + 1 + QB + 1;
  localparam int TOTAL_LAT  = 2 * UNIT_LAT + 6;

  localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;

  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [IN_W-1:0]   in_t;
  typedef logic signed [P_W-1:0]    prod_t;
  typedef logic signed [PROD_W-1:0] acc_t;

  // Shift right by FRAC_BITS, rounding half away from zero.
  function automatic acc_t round_shift(acc_t p);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] r;
    m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    r = (m + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return p[PROD_W-1] ? -acc_t'(r) : acc_t'(r);
  endfunction

  function automatic unit_t clamp_one(acc_t v);
    acc_t one;
    one = acc_t'(ONE_Q);
    if (v > one) return unit_t'(one);
    if (v < -one) return unit_t'(-one);
    return unit_t'(v);
  endfunction

  function automatic logic signed [SHIFT_W-1:0] sat32(acc_t v);
    acc_t hi;
    acc_t lo;
    hi = acc_t'({1'b0, {(SHIFT_W-1){1'b1}}});
    lo = -hi - acc_t'(1);
    if (v > hi) return SHIFT_W'(hi);
    if (v < lo) return SHIFT_W'(lo);
    return SHIFT_W'(v);
  endfunction

endpackage

[design/lvm_unit3.sv]
// ----------------------------------------------------------------------------
// lvm_unit3
// Pipelined 3-vector normalizer: scale, sum of squares, bit-serial square
// root stages and restoring divide stages, one vector per cycle with en high.
// ----------------------------------------------------------------------------
module lvm_unit3 (
  input  logic           clk,
  input  logic           en,
  input  lvm_pkg::vec_t  vec_in [3],
  output lvm_pkg::unit_t unit_out [3],
  output logic           nonzero
);

  localparam int NW = lvm_pkg::NORM_W;
  localparam int SS = lvm_pkg::SQRT_STEPS;
  localparam int QB = lvm_pkg::QB;

  function automatic logic [3:0] lead16(logic [15:0] x);
    logic [3:0] p;
    p = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (x[b]) p = 4'(b);
    end
    return p;
  endfunction

  // Magnitudes and signs.
  logic [lvm_pkg::VEC_W-1:0] mag1 [3];
  logic [2:0]                neg1;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= vec_in[i][lvm_pkg::VEC_W-1];
        mag1[i] <= vec_in[i][lvm_pkg::VEC_W-1] ? lvm_pkg::VEC_W'(-vec_in[i])
                                                : lvm_pkg::VEC_W'(vec_in[i]);
      end
    end
  end

  // Largest magnitude.
  logic [lvm_pkg::VEC_W-1:0] mag2 [3];
  logic [lvm_pkg::VEC_W-1:0] mx2;
  logic [2:0]                neg2;
  logic [lvm_pkg::VEC_W-1:0] mx_c;
  always_comb begin
    mx_c = mag1[0];
    if (mag1[1] > mx_c) mx_c = mag1[1];
    if (mag1[2] > mx_c) mx_c = mag1[2];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mag2 <= mag1;
      neg2 <= neg1;
      mx2  <= mx_c;
    end
  end

  // Leading one, first per 16-bit chunk, then across chunks.
  logic [lvm_pkg::VEC_W-1:0] mag3 [3];
  logic [2:0]                neg3;
  logic [lvm_pkg::CHUNKS-1:0] any3;
  logic [3:0]                lp3 [lvm_pkg::CHUNKS];
  always_ff @(posedge clk) begin
    if (en) begin
      mag3 <= mag2;
      neg3 <= neg2;
      for (int k = 0; k < lvm_pkg::CHUNKS; k++) begin
        any3[k] <= |mx2[16*k +: 16];
        lp3[k]  <= lead16(mx2[16*k +: 16]);
      end
    end
  end

  logic [lvm_pkg::VEC_W-1:0] mag4 [3];
  logic [2:0]                neg4;
  logic [lvm_pkg::POS_W-1:0] pos4;
  logic                      nz4;
  logic [lvm_pkg::POS_W-1:0] pos_c;
  always_comb begin
    pos_c = '0;
    for (int k = 0; k < lvm_pkg::CHUNKS; k++) begin
      if (any3[k]) pos_c = {2'(k), lp3[k]};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mag4 <= mag3;
      neg4 <= neg3;
      pos4 <= pos_c;
      nz4  <= |any3;
    end
  end

  // Bring the largest magnitude into [2^30, 2^31); right shifts truncate.
  logic [NW-1:0] m5 [3];
  logic [2:0]    neg5;
  logic          nz5;
  always_ff @(posedge clk) begin
    if (en) begin
      neg5 <= neg4;
      nz5  <= nz4;
      for (int i = 0; i < 3; i++) begin
        if (pos4 >= lvm_pkg::POS_W'(NW - 1)) begin
          m5[i] <= NW'(mag4[i] >> (pos4 - lvm_pkg::POS_W'(NW - 1)));
        end else begin
          m5[i] <= NW'(mag4[i] << (lvm_pkg::POS_W'(NW - 1) - pos4));
        end
      end
    end
  end

  logic [lvm_pkg::SQ_W-1:0] sq6 [3];
  logic [NW-1:0]            m6 [3];
  logic [2:0]               neg6;
  logic                     nz6;
  always_ff @(posedge clk) begin
    if (en) begin
      m6   <= m5;
      neg6 <= neg5;
      nz6  <= nz5;
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= m5[i] * m5[i];
      end
    end
  end

  // Square root pipeline: stage 0 holds the sum of squares.
  logic [lvm_pkg::SUM_W-1:0]  s_s    [SS+1];
  logic [lvm_pkg::ROOT_W-1:0] root_s [SS+1];
  logic [lvm_pkg::REM_W-1:0]  rem_s  [SS+1];
  logic [NW-1:0]              m_s    [SS+1][3];
  logic [2:0]                 neg_s  [SS+1];
  logic                       nz_s   [SS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      s_s[0]    <= lvm_pkg::SUM_W'(sq6[0]) + lvm_pkg::SUM_W'(sq6[1])
                   + lvm_pkg::SUM_W'(sq6[2]);
      root_s[0] <= '0;
      rem_s[0]  <= '0;
      m_s[0]    <= m6;
      neg_s[0]  <= neg6;
      nz_s[0]   <= nz6;
    end
  end

  for (genvar j = 0; j < SS; j++) begin : g_sqrt
    logic [lvm_pkg::REM_W-1:0] rem_sh;
    logic [lvm_pkg::REM_W-1:0] trial;
    assign rem_sh = {rem_s[j][lvm_pkg::REM_W-3:0],
                     s_s[j][lvm_pkg::SUM_W-1-2*j -: 2]};
    assign trial  = lvm_pkg::REM_W'({root_s[j], 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        s_s[j+1]   <= s_s[j];
        m_s[j+1]   <= m_s[j];
        neg_s[j+1] <= neg_s[j];
        nz_s[j+1]  <= nz_s[j];
        if (rem_sh >= trial) begin
          rem_s[j+1]  <= rem_sh - trial;
          root_s[j+1] <= {root_s[j][lvm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_s[j+1]  <= rem_sh;
          root_s[j+1] <= {root_s[j][lvm_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Divide pipeline: quotient of (m << FRAC_BITS) + len/2 by len.
  logic [lvm_pkg::DREM_W-1:0] d_rem [QB+1][3];
  logic [QB-1:0]              d_q   [QB+1][3];
  logic [lvm_pkg::ROOT_W-1:0] d_len [QB+1];
  logic [2:0]                 d_neg [QB+1];
  logic                       d_nz  [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      d_len[0] <= root_s[SS];
      d_neg[0] <= neg_s[SS];
      d_nz[0]  <= nz_s[SS];
      for (int i = 0; i < 3; i++) begin
        d_rem[0][i] <= (lvm_pkg::DREM_W'(m_s[SS][i]) << lvm_pkg::FRAC_BITS)
                       + lvm_pkg::DREM_W'(root_s[SS] >> 1);
        d_q[0][i]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [lvm_pkg::DREM_W-1:0] dv;
    assign dv = lvm_pkg::DREM_W'(d_len[j]) << (QB - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        d_len[j+1] <= d_len[j];
        d_neg[j+1] <= d_neg[j];
        d_nz[j+1]  <= d_nz[j];
        for (int i = 0; i < 3; i++) begin
          if (d_rem[j][i] >= dv) begin
            d_rem[j+1][i] <= d_rem[j][i] - dv;
            d_q[j+1][i]   <= d_q[j][i] | (QB'(1) << (QB - 1 - j));
          end else begin
            d_rem[j+1][i] <= d_rem[j][i];
            d_q[j+1][i]   <= d_q[j][i];
          end
        end
      end
    end
  end

  // Clamp to one, restore sign, force zero for a zero vector.
  always_ff @(posedge clk) begin
    if (en) begin
      nonzero <= d_nz[QB];
      for (int i = 0; i < 3; i++) begin
        if (!d_nz[QB]) begin
          unit_out[i] <= '0;
        end else if (d_q[QB][i] > lvm_pkg::ONE_Q) begin
          unit_out[i] <= d_neg[QB][i] ? -lvm_pkg::unit_t'(lvm_pkg::ONE_Q)
                                      : lvm_pkg::unit_t'(lvm_pkg::ONE_Q);
        end else begin
          unit_out[i] <= d_neg[QB][i] ? -lvm_pkg::unit_t'(d_q[QB][i])
                                      : lvm_pkg::unit_t'(d_q[QB][i]);
        end
      end
    end
  end

endmodule

[design/look_at_view_matrix_top.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Builds a right-handed look-at view matrix from eye, look and up vectors.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) carries one word of eye,
// look and up vectors in signed Q16.16. The output channel (out_valid,
// out_stall) returns one word with the rotation rows right, true_up and
// back and the three translations shift_x/y/z.
// The pipeline is two normalizer pipelines of 59 stages each (32 square
// root stages and 18 divide stages among them), two stages for the cross
// product and four for the second cross product and the dot products.
// Throughput is one word per cycle. The whole pipeline advances together;
// when out_stall holds a waiting word, every stage holds and in_stall rises
// in the same cycle, so no word is lost or repeated.
// Reset clears all valid bits; the block accepts a word in the first cycle
// after reset. A zero look vector, or one parallel to up, gives all zeros.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_top_macros.svh"

module look_at_view_matrix_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lvm_pkg::IN_W-1:0]     eye_x,
  input  logic signed [lvm_pkg::IN_W-1:0]     eye_y,
  input  logic signed [lvm_pkg::IN_W-1:0]     eye_z,
  input  logic signed [lvm_pkg::IN_W-1:0]     look_x,
  input  logic signed [lvm_pkg::IN_W-1:0]     look_y,
  input  logic signed [lvm_pkg::IN_W-1:0]     look_z,
  input  logic signed [lvm_pkg::IN_W-1:0]     up_x,
  input  logic signed [lvm_pkg::IN_W-1:0]     up_y,
  input  logic signed [lvm_pkg::IN_W-1:0]     up_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lvm_pkg::OUT_W-1:0]    right_x,
  output logic signed [lvm_pkg::OUT_W-1:0]    right_y,
  output logic signed [lvm_pkg::OUT_W-1:0]    right_z,
  output logic signed [lvm_pkg::OUT_W-1:0]    true_up_x,
  output logic signed [lvm_pkg::OUT_W-1:0]    true_up_y,
  output logic signed [lvm_pkg::OUT_W-1:0]    true_up_z,
  output logic signed [lvm_pkg::OUT_W-1:0]    back_x,
  output logic signed [lvm_pkg::OUT_W-1:0]    back_y,
  output logic signed [lvm_pkg::OUT_W-1:0]    back_z,
  output logic signed [lvm_pkg::SHIFT_W-1:0]  shift_x,
  output logic signed [lvm_pkg::SHIFT_W-1:0]  shift_y,
  output logic signed [lvm_pkg::SHIFT_W-1:0]  shift_z
);

  localparam int UL = lvm_pkg::UNIT_LAT;
  localparam int TL = lvm_pkg::TOTAL_LAT;

  logic adv;
  logic [TL-1:0] vld;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[TL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TL-2:0], in_valid};
    end
  end

  // First normalizer: unit forward vector.
  lvm_pkg::vec_t  look_vec [3];
  lvm_pkg::unit_t f_u [3];
  logic           f_nz;

  assign look_vec[0] = lvm_pkg::vec_t'(look_x);
  assign look_vec[1] = lvm_pkg::vec_t'(look_y);
  assign look_vec[2] = lvm_pkg::vec_t'(look_z);

  lvm_unit3 u_fwd (
    .clk      (clk),
    .en       (adv),
    .vec_in   (look_vec),
    .unit_out (f_u),
    .nonzero  (f_nz)
  );

  // Eye and up ride alongside the first normalizer.
  lvm_pkg::in_t eye_d1 [UL][3];
  lvm_pkg::in_t up_d1  [UL][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      eye_d1[0][0] <= eye_x;
      eye_d1[0][1] <= eye_y;
      eye_d1[0][2] <= eye_z;
      up_d1[0][0]  <= up_x;
      up_d1[0][1]  <= up_y;
      up_d1[0][2]  <= up_z;
      for (int k = 1; k < UL; k++) begin
        eye_d1[k] <= eye_d1[k-1];
        up_d1[k]  <= up_d1[k-1];
      end
    end
  end

  // Cross product f x up at full precision.
  lvm_pkg::prod_t  xp [6];
  lvm_pkg::unit_t  f_x1 [3];
  lvm_pkg::in_t    eye_x1 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      // A zero look vector leaves nothing to cross.
      if (f_nz) begin
        xp[0] <= f_u[1] * up_d1[UL-1][2];
        xp[1] <= f_u[2] * up_d1[UL-1][1];
        xp[2] <= f_u[2] * up_d1[UL-1][0];
        xp[3] <= f_u[0] * up_d1[UL-1][2];
        xp[4] <= f_u[0] * up_d1[UL-1][1];
        xp[5] <= f_u[1] * up_d1[UL-1][0];
      end else begin
        for (int i = 0; i < 6; i++) begin
          xp[i] <= '0;
        end
      end
      f_x1   <= f_u;
      eye_x1 <= eye_d1[UL-1];
    end
  end

  logic signed [lvm_pkg::CROSS_W-1:0] cr [3];
  lvm_pkg::unit_t f_x2 [3];
  lvm_pkg::in_t   eye_x2 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cr[i] <= lvm_pkg::CROSS_W'(xp[2*i]) - lvm_pkg::CROSS_W'(xp[2*i+1]);
      end
      f_x2   <= f_x1;
      eye_x2 <= eye_x1;
    end
  end

  // Second normalizer: unit right vector.
  lvm_pkg::vec_t  c_vec [3];
  lvm_pkg::unit_t r_u [3];
  logic           r_nz;

  for (genvar i = 0; i < 3; i++) begin : g_cvec
    assign c_vec[i] = lvm_pkg::vec_t'(cr[i]);
  end

  lvm_unit3 u_right (
    .clk      (clk),
    .en       (adv),
    .vec_in   (c_vec),
    .unit_out (r_u),
    .nonzero  (r_nz)
  );

  lvm_pkg::unit_t f_d2   [UL][3];
  lvm_pkg::in_t   eye_d2 [UL][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      f_d2[0]   <= f_x2;
      eye_d2[0] <= eye_x2;
      for (int k = 1; k < UL; k++) begin
        f_d2[k]   <= f_d2[k-1];
        eye_d2[k] <= eye_d2[k-1];
      end
    end
  end

  // Products for u = r x f and the dot products with eye.
  lvm_pkg::prod_t rf_y1 [6];
  lvm_pkg::prod_t re_y1 [3];
  lvm_pkg::prod_t fe_y1 [3];
  lvm_pkg::unit_t r_y1 [3];
  lvm_pkg::unit_t f_y1 [3];
  lvm_pkg::in_t   eye_y1 [3];
  logic           nz_y1;
  always_ff @(posedge clk) begin
    if (adv) begin
      rf_y1[0] <= r_u[1] * f_d2[UL-1][2];
      rf_y1[1] <= r_u[2] * f_d2[UL-1][1];
      rf_y1[2] <= r_u[2] * f_d2[UL-1][0];
      rf_y1[3] <= r_u[0] * f_d2[UL-1][2];
      rf_y1[4] <= r_u[0] * f_d2[UL-1][1];
      rf_y1[5] <= r_u[1] * f_d2[UL-1][0];
      for (int i = 0; i < 3; i++) begin
        re_y1[i] <= r_u[i] * eye_d2[UL-1][i];
        fe_y1[i] <= f_d2[UL-1][i] * eye_d2[UL-1][i];
      end
      r_y1   <= r_u;
      f_y1   <= f_d2[UL-1];
      eye_y1 <= eye_d2[UL-1];
      nz_y1  <= r_nz;
    end
  end

  lvm_pkg::unit_t u_y2 [3];
  lvm_pkg::acc_t  dr_y2;
  lvm_pkg::acc_t  df_y2;
  lvm_pkg::unit_t r_y2 [3];
  lvm_pkg::unit_t f_y2 [3];
  lvm_pkg::in_t   eye_y2 [3];
  logic           nz_y2;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u_y2[i] <= lvm_pkg::clamp_one(lvm_pkg::round_shift(
                     lvm_pkg::acc_t'(rf_y1[2*i]) - lvm_pkg::acc_t'(rf_y1[2*i+1])));
      end
      dr_y2  <= lvm_pkg::acc_t'(re_y1[0]) + lvm_pkg::acc_t'(re_y1[1])
                + lvm_pkg::acc_t'(re_y1[2]);
      df_y2  <= lvm_pkg::acc_t'(fe_y1[0]) + lvm_pkg::acc_t'(fe_y1[1])
                + lvm_pkg::acc_t'(fe_y1[2]);
      r_y2   <= r_y1;
      f_y2   <= f_y1;
      eye_y2 <= eye_y1;
      nz_y2  <= nz_y1;
    end
  end

  lvm_pkg::prod_t ue_y3 [3];
  logic signed [lvm_pkg::SHIFT_W-1:0] sx_y3;
  logic signed [lvm_pkg::SHIFT_W-1:0] sz_y3;
  lvm_pkg::unit_t r_y3 [3];
  lvm_pkg::unit_t u_y3 [3];
  lvm_pkg::unit_t f_y3 [3];
  logic           nz_y3;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ue_y3[i] <= u_y2[i] * eye_y2[i];
      end
      sx_y3 <= lvm_pkg::sat32(-lvm_pkg::round_shift(dr_y2));
      sz_y3 <= lvm_pkg::sat32(lvm_pkg::round_shift(df_y2));
      r_y3  <= r_y2;
      u_y3  <= u_y2;
      f_y3  <= f_y2;
      nz_y3 <= nz_y2;
    end
  end

  // Output word; a degenerate frame gives all zeros.
  lvm_pkg::acc_t du_c;
  assign du_c = lvm_pkg::acc_t'(ue_y3[0]) + lvm_pkg::acc_t'(ue_y3[1])
                + lvm_pkg::acc_t'(ue_y3[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (nz_y3) begin
        right_x   <= lvm_pkg::OUT_W'(r_y3[0]);
        right_y   <= lvm_pkg::OUT_W'(r_y3[1]);
        right_z   <= lvm_pkg::OUT_W'(r_y3[2]);
        true_up_x <= lvm_pkg::OUT_W'(u_y3[0]);
        true_up_y <= lvm_pkg::OUT_W'(u_y3[1]);
        true_up_z <= lvm_pkg::OUT_W'(u_y3[2]);
        back_x    <= lvm_pkg::OUT_W'(-f_y3[0]);
        back_y    <= lvm_pkg::OUT_W'(-f_y3[1]);
        back_z    <= lvm_pkg::OUT_W'(-f_y3[2]);
        shift_x   <= sx_y3;
        shift_y   <= lvm_pkg::sat32(-lvm_pkg::round_shift(du_c));
        shift_z   <= sz_y3;
      end else begin
        right_x   <= '0;
        right_y   <= '0;
        right_z   <= '0;
        true_up_x <= '0;
        true_up_y <= '0;
        true_up_z <= '0;
        back_x    <= '0;
        back_y    <= '0;
        back_z    <= '0;
        shift_x   <= '0;
        shift_y   <= '0;
        shift_z   <= '0;
      end
    end
  end

  `LVM_ASSERT_HOLDS(a_stall_only_when_held, 1'b1, in_stall == (out_valid && out_stall),
                    "in_stall must follow a held output word")
  `LVM_ASSERT_HOLDS(a_zero_frame,
                    out_valid && right_x == 0 && right_y == 0 && right_z == 0,
                    back_x == 0 && back_y == 0 && back_z == 0 && shift_z == 0,
                    "zero right vector must come with a zero frame")
  `LVM_ASSERT_AFTER_RESET(a_reset_empty, !out_valid && !in_stall,
                          "pipeline must be empty after reset")

endmodule
